### src/apc_pkg.sv
// shared constants, types and the control store of the averaged pid phase-angle controller
package apc_pkg;

  // default length of the reference averaging window
  localparam int WINDOW_DEF = 64;

  // field and datapath widths
  localparam int SAMPLE_W    = 10;
  localparam int SPEED_W     = 16;
  localparam int TICKS_W     = 16;
  localparam int GAIN_W      = 16;
  localparam int LEVEL_W     = 10;
  localparam int DELAY_W     = 16;
  localparam int SPD_W       = 12;
  localparam int ERR_W       = 13;
  localparam int DIFF_W      = 14;
  localparam int INTEG_W     = 26;
  localparam int ISUM_W      = 28;
  localparam int ACC_W       = 56;
  localparam int MUL_W       = 32;
  localparam int PROD_W      = 64;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int UPC_W       = 4;

  // fixed-point constants
  localparam logic [MUL_W-1:0] SPEED_SCALE = 32'd2235;   // 0.0341 in Q0.16
  localparam logic [MUL_W-1:0] TS_Q16      = 32'd1088;   // 0.0166 s in Q0.16
  localparam logic [MUL_W-1:0] INV_TS_Q8   = 32'd15421;  // 1/Ts in Q8.8

  // register reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST     = 16'd512;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST    = 16'd256;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST    = 16'd0;
  localparam logic [LEVEL_W-1:0] DRIVE_FLOOR_RST   = 10'd10;
  localparam logic [LEVEL_W-1:0] DRIVE_CEILING_RST = 10'd1020;
  localparam logic [LEVEL_W-1:0] INTEG_CEILING_RST = 10'd1020;
  localparam logic [DELAY_W-1:0] HELD_DELAY_RST    = 16'hFFFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_DRIVE_FLOOR,
    REG_DRIVE_CEILING,
    REG_INTEG_CEILING
  } cfg_reg_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SPEED,   // rpm * speed scale
    MUL_AVG,     // window sum * reciprocal of window length
    MUL_DGI,     // deriv gain * 1/Ts
    MUL_DERIV,   // (deriv gain / Ts) * error difference
    MUL_ISTEP,   // error * Ts
    MUL_PTERM,   // error * prop gain
    MUL_ITERM,   // integral * integ gain
    MUL_DELAY    // (ticks >> 10) * drive
  } mul_sel_t;

  // register update done by a step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WINDOW,
    OP_SPEED,
    OP_ERROR,
    OP_ACC_D,
    OP_INTEG,
    OP_ACC_P,
    OP_DRIVE,
    OP_DELAY,
    OP_HOLD
  } op_t;

  typedef logic [UPC_W-1:0] upc_t;

  // one control word
  typedef struct packed {
    op_t      op;
    mul_sel_t mul;
    logic     jump_zero;  // jump to target when the new error is zero
    upc_t     target;
    logic     last;       // step that hands the result over
  } ucode_t;

  localparam upc_t STEP_HOLD = 4'd10;

  // control store
  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    w = '{op: OP_NOP, mul: MUL_NONE, jump_zero: 1'b0, target: '0, last: 1'b0};
    unique case (pc)
      4'd0: begin
        w.op  = OP_WINDOW;
        w.mul = MUL_SPEED;
      end
      4'd1: begin
        w.op  = OP_SPEED;
        w.mul = MUL_AVG;
      end
      4'd2: begin
        w.op        = OP_ERROR;
        w.mul       = MUL_DGI;
        w.jump_zero = 1'b1;
        w.target    = STEP_HOLD;
      end
      4'd3: begin
        w.mul = MUL_DERIV;
      end
      4'd4: begin
        w.op  = OP_ACC_D;
        w.mul = MUL_ISTEP;
      end
      4'd5: begin
        w.op  = OP_INTEG;
        w.mul = MUL_PTERM;
      end
      4'd6: begin
        w.op  = OP_ACC_P;
        w.mul = MUL_ITERM;
      end
      4'd7: begin
        w.op = OP_DRIVE;
      end
      4'd8: begin
        w.mul = MUL_DELAY;
      end
      4'd9: begin
        w.op   = OP_DELAY;
        w.last = 1'b1;
      end
      STEP_HOLD: begin
        w.op   = OP_HOLD;
        w.last = 1'b1;
      end
      default: begin
        w.op   = OP_HOLD;
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

### src/apc_ram.sv
// generic single-port-write ram with registered read
module apc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/averaged_pid_phase_angle_control_core.sv
// Averaged PID phase-angle controller, one item per mains half-cycle.
//
// Input stream (s_*): one transaction per half-cycle carries the reference
// sample, the measured rpm and the half-cycle length in timer ticks.
// Output stream (m_*): exactly one transaction per input, with the drive
// level and triac fire delay in m_tdata and the updated flag in m_tuser.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 prop
// gain, 1 integ gain, 2 deriv gain, 3 drive floor, 4 drive ceiling,
// 5 integ ceiling); other indexes are ignored. Write only while idle.
// Timing: a microcoded sequencer steps one shared 32x32 multiplier through
// the item, one step per cycle after the accepting edge unless the last
// step is stalled: 10 steps for a nonzero error, 4 when the error is zero.
// The last step loads the output register, which raises m_tvalid.
// s_tready is low from the accepting edge to the last step, so a new item
// is not taken until the last step of the one in work is done.
// The output register frees the engine: a new item is taken while a result
// waits; if the receiver stalls, the engine holds at its last step.
// Reset clears the window (through a fill flag, no clearing pass), the
// integral and previous error, and restores register defaults.
module averaged_pid_phase_angle_control_core #(
  parameter int WINDOW = apc_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [apc_pkg::IN_TDATA_W-1:0]  s_tdata,   // reference_sample, speed_rpm, half_cycle_ticks
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [apc_pkg::OUT_TDATA_W-1:0] m_tdata,   // drive_level, fire_delay
  output logic                            m_tuser,   // updated
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [apc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apc_pkg::CFG_W-1:0]       cfg_wdata
);
  import apc_pkg::*;

  localparam int PTR_W = $clog2(WINDOW);
  localparam int SUM_W = SAMPLE_W + PTR_W;
  localparam int SH    = SUM_W + PTR_W;
  localparam int RECIP = ((1 << SH) + WINDOW - 1) / WINDOW;

  // configuration registers
  logic [GAIN_W-1:0]  prop_gain, integ_gain, deriv_gain;
  logic [LEVEL_W-1:0] drive_floor, drive_ceiling, integ_ceiling;

  // sequencer
  logic   busy;
  upc_t   upc;
  ucode_t uw;
  logic   stall, advance;

  // item and datapath registers
  logic [SAMPLE_W-1:0]     sample;
  logic [SPEED_W-1:0]      rpm;
  logic [TICKS_W-1:0]      ticks;
  logic [SUM_W-1:0]        win_sum;
  logic [PTR_W-1:0]        ptr;
  logic                    filled;
  logic signed [PROD_W-1:0] prod;
  logic [SPD_W-1:0]        spd;
  logic signed [ERR_W-1:0] err, prev_err;
  logic [INTEG_W-1:0]      integ;
  logic signed [ACC_W-1:0] acc;
  logic [LEVEL_W-1:0]      held_drive;
  logic [DELAY_W-1:0]      held_delay;

  // combinational values
  logic [SAMPLE_W-1:0]      ram_rdata, old_sample, avg;
  logic [SUM_W-1:0]         sum_next;
  logic                     ptr_last;
  logic signed [ERR_W-1:0]  err_next;
  logic signed [DIFF_W-1:0] diff;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [ISUM_W-1:0] isum;
  logic [INTEG_W-1:0]       integ_limit, integ_next;
  logic signed [ACC_W-1:0]  total;
  logic [MUL_W-1:0]         quot, lvl;
  logic [LEVEL_W-1:0]       drive_next;
  logic [DELAY_W-1:0]       delay_next;

  // handshake and step control
  assign uw       = ucode_rom(upc);
  assign s_tready = !busy;
  assign stall    = uw.last && m_tvalid && !m_tready;
  assign advance  = busy && !stall;

  // sample window store
  apc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (advance && (uw.op == OP_WINDOW)),
    .waddr (ptr),
    .wdata (sample),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  // window arithmetic; entries not yet written read as zero
  assign old_sample = filled ? ram_rdata : '0;
  assign sum_next   = win_sum - SUM_W'(old_sample) + SUM_W'(sample);
  assign ptr_last   = (ptr == PTR_W'(WINDOW - 1));

  // error and its difference
  assign avg      = prod[SH +: SAMPLE_W];
  assign err_next = $signed({3'b000, avg}) - $signed({1'b0, spd});
  assign diff     = $signed({err[ERR_W-1], err}) - $signed({prev_err[ERR_W-1], prev_err});

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.mul)
      MUL_SPEED: begin
        mul_a = $signed(MUL_W'(rpm));
        mul_b = $signed(SPEED_SCALE);
      end
      MUL_AVG: begin
        mul_a = $signed(MUL_W'(win_sum));
        mul_b = $signed(MUL_W'(RECIP));
      end
      MUL_DGI: begin
        mul_a = $signed(MUL_W'(deriv_gain));
        mul_b = $signed(INV_TS_Q8);
      end
      MUL_DERIV: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = MUL_W'(diff);
      end
      MUL_ISTEP: begin
        mul_a = MUL_W'(err);
        mul_b = $signed(TS_Q16);
      end
      MUL_PTERM: begin
        mul_a = MUL_W'(err);
        mul_b = $signed(MUL_W'(prop_gain));
      end
      MUL_ITERM: begin
        mul_a = $signed(MUL_W'(integ));
        mul_b = $signed(MUL_W'(integ_gain));
      end
      MUL_DELAY: begin
        mul_a = $signed(MUL_W'(ticks[TICKS_W-1:10]));
        mul_b = $signed(MUL_W'(held_drive));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // integral update with clamp to 0..ceiling
  assign integ_limit = {integ_ceiling, 16'h0000};
  assign isum        = $signed({2'b00, integ}) + prod[ISUM_W-1:0];
  always_comb begin
    if (isum < 0) begin
      integ_next = '0;
    end else if (isum > $signed({2'b00, integ_limit})) begin
      integ_next = integ_limit;
    end else begin
      integ_next = isum[INTEG_W-1:0];
    end
  end

  // drive: sum scaled down by 2^24, floor then ceiling; negative sums end at the floor
  assign total = acc + prod[ACC_W-1:0];
  assign quot  = total[ACC_W-1:24];
  always_comb begin
    if (total[ACC_W-1] || (quot < MUL_W'(drive_floor))) begin
      lvl = MUL_W'(drive_floor);
    end else begin
      lvl = quot;
    end
    if (lvl > MUL_W'(drive_ceiling)) begin
      drive_next = drive_ceiling;
    end else begin
      drive_next = lvl[LEVEL_W-1:0];
    end
  end

  assign delay_next = ticks - prod[DELAY_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= PROP_GAIN_RST;
      integ_gain    <= INTEG_GAIN_RST;
      deriv_gain    <= DERIV_GAIN_RST;
      drive_floor   <= DRIVE_FLOOR_RST;
      drive_ceiling <= DRIVE_CEILING_RST;
      integ_ceiling <= INTEG_CEILING_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PROP_GAIN:     prop_gain     <= cfg_wdata;
        REG_INTEG_GAIN:    integ_gain    <= cfg_wdata;
        REG_DERIV_GAIN:    deriv_gain    <= cfg_wdata;
        REG_DRIVE_FLOOR:   drive_floor   <= cfg_wdata[LEVEL_W-1:0];
        REG_DRIVE_CEILING: drive_ceiling <= cfg_wdata[LEVEL_W-1:0];
        REG_INTEG_CEILING: integ_ceiling <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= '0;
    end else if (s_tvalid && s_tready) begin
      busy <= 1'b1;
      upc  <= '0;
    end else if (advance) begin
      if (uw.last) begin
        busy <= 1'b0;
        upc  <= '0;
      end else if (uw.jump_zero && (err_next == '0)) begin
        upc <= uw.target;
      end else begin
        upc <= upc + 1'b1;
      end
    end
  end

  // item capture and working registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample <= s_tdata[SAMPLE_W-1:0];
      rpm    <= s_tdata[SAMPLE_W +: SPEED_W];
      ticks  <= s_tdata[SAMPLE_W + SPEED_W +: TICKS_W];
    end
    if (advance) begin
      prod <= prod_next;
      case (uw.op)
        OP_SPEED: spd <= prod[16 +: SPD_W];
        OP_ERROR: err <= err_next;
        OP_ACC_D: acc <= {prod[ACC_W-9:0], 8'h00};
        OP_ACC_P: acc <= acc + {prod[ACC_W-17:0], 16'h0000};
        default: ;
      endcase
    end
  end

  // controller state kept across items
  always_ff @(posedge clk) begin
    if (rst) begin
      win_sum    <= '0;
      ptr        <= '0;
      filled     <= 1'b0;
      prev_err   <= '0;
      integ      <= '0;
      held_drive <= '0;
      held_delay <= HELD_DELAY_RST;
    end else if (advance) begin
      case (uw.op)
        OP_WINDOW: begin
          win_sum <= sum_next;
          ptr     <= ptr_last ? '0 : ptr + 1'b1;
          if (ptr_last) begin
            filled <= 1'b1;
          end
        end
        OP_INTEG: integ <= integ_next;
        OP_DRIVE: begin
          held_drive <= drive_next;
          prev_err   <= err;
        end
        OP_DELAY: held_delay <= delay_next;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (advance && uw.last) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && uw.last) begin
      if (uw.op == OP_DELAY) begin
        m_tdata <= OUT_TDATA_W'({delay_next, held_drive});
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= OUT_TDATA_W'({held_delay, held_drive});
        m_tuser <= 1'b0;
      end
    end
  end

endmodule

### src/apc_checker.sv
// port-level checks on the phase-angle controller, bound to the top level
module apc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [apc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                            m_tuser
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output transaction changed while stalled");

  // the engine is free and the output empty right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // only one item is in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while one is in work");

  // a result appears only at the end of an item in work
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without an item in work");

endmodule

bind averaged_pid_phase_angle_control_core apc_checker u_apc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
